### hw/rtl/plp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_pkg
// Shared widths, microcode word layout and the control program of the
// path length and peak speed block.
// ----------------------------------------------------------------------------
package plp_pkg;

	localparam int CoordWidthDef = 24;
	localparam int SumWidthDef   = 48;

	localparam int PcWidth = 4;
	typedef logic [PcWidth-1:0] plp_pc_t;

	typedef logic [2:0] plp_cond_t;
	localparam plp_cond_t COND_NEVER    = 3'd0;
	localparam plp_cond_t COND_NO_ITEM  = 3'd1;
	localparam plp_cond_t COND_NO_LAST  = 3'd2;
	localparam plp_cond_t COND_CNT_NZ   = 3'd3;
	localparam plp_cond_t COND_OUT_BUSY = 3'd4;

	typedef logic [1:0] plp_axis_t;
	localparam plp_axis_t AXIS_X = 2'd0;
	localparam plp_axis_t AXIS_Y = 2'd1;
	localparam plp_axis_t AXIS_Z = 2'd2;

	localparam plp_pc_t STEP_WAIT   = 4'd0;
	localparam plp_pc_t STEP_DX     = 4'd1;
	localparam plp_pc_t STEP_DY     = 4'd2;
	localparam plp_pc_t STEP_DZ     = 4'd3;
	localparam plp_pc_t STEP_ACC_Y  = 4'd4;
	localparam plp_pc_t STEP_ACC_Z  = 4'd5;
	localparam plp_pc_t STEP_SQ_INI = 4'd6;
	localparam plp_pc_t STEP_SQ_IT  = 4'd7;
	localparam plp_pc_t STEP_ADD    = 4'd8;
	localparam plp_pc_t STEP_FIN    = 4'd9;

	typedef struct packed {
		logic      take;
		logic      ld_diff;
		plp_axis_t axis;
		logic      mul;
		logic      acc_clr;
		logic      acc_add;
		logic      sq_init;
		logic      sq_step;
		logic      add_len;
		logic      fin;
		logic      last;
		plp_cond_t cond;
		plp_pc_t   target;
	} plp_ctl_t;

	typedef struct packed {
		logic accept;
		logic have_last;
		logic cnt_nz;
		logic out_busy;
	} plp_status_t;

	function automatic plp_ctl_t plp_ucode(input plp_pc_t pc);
		plp_ctl_t c;
		c = '0;
		c.axis = AXIS_X;
		c.cond = COND_NEVER;
		c.target = STEP_WAIT;
		unique case (pc)
			STEP_WAIT: begin
				c.take = 1'b1;
				c.cond = COND_NO_ITEM;
				c.target = STEP_WAIT;
			end
			STEP_DX: begin
				c.ld_diff = 1'b1;
				c.axis = AXIS_X;
				c.cond = COND_NO_LAST;
				c.target = STEP_FIN;
			end
			STEP_DY: begin
				c.mul = 1'b1;
				c.ld_diff = 1'b1;
				c.axis = AXIS_Y;
			end
			STEP_DZ: begin
				c.acc_clr = 1'b1;
				c.mul = 1'b1;
				c.ld_diff = 1'b1;
				c.axis = AXIS_Z;
			end
			STEP_ACC_Y: begin
				c.acc_add = 1'b1;
				c.mul = 1'b1;
			end
			STEP_ACC_Z: begin
				c.acc_add = 1'b1;
			end
			STEP_SQ_INI: begin
				c.sq_init = 1'b1;
			end
			STEP_SQ_IT: begin
				c.sq_step = 1'b1;
				c.cond = COND_CNT_NZ;
				c.target = STEP_SQ_IT;
			end
			STEP_ADD: begin
				c.add_len = 1'b1;
			end
			STEP_FIN: begin
				c.fin = 1'b1;
				c.last = 1'b1;
				c.cond = COND_OUT_BUSY;
				c.target = STEP_FIN;
			end
			default: begin
				c.last = 1'b1;
			end
		endcase
		return c;
	endfunction

endpackage

### hw/rtl/plp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_in_if / plp_out_if
// Valid/ready channels for trajectory points and for running results.
// ----------------------------------------------------------------------------
interface plp_in_if import plp_pkg::*; #(
	parameter int COORD_WIDTH = CoordWidthDef
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] x_coord;
	logic signed [COORD_WIDTH-1:0] y_coord;
	logic signed [COORD_WIDTH-1:0] z_coord;
	logic signed [COORD_WIDTH-1:0] speed_value;
	logic                          restart;

	modport source (
		output valid, x_coord, y_coord, z_coord, speed_value, restart,
		input  ready
	);
	modport sink (
		input  valid, x_coord, y_coord, z_coord, speed_value, restart,
		output ready
	);
endinterface

interface plp_out_if import plp_pkg::*; #(
	parameter int COORD_WIDTH = CoordWidthDef,
	parameter int SUM_WIDTH   = SumWidthDef
);
	logic                   valid;
	logic                   ready;
	logic [SUM_WIDTH-1:0]   total_length;
	logic [COORD_WIDTH-2:0] peak_speed;

	modport source (
		output valid, total_length, peak_speed,
		input  ready
	);
	modport sink (
		input  valid, total_length, peak_speed,
		output ready
	);
endinterface

### hw/rtl/path_length_and_peak_speed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_length_and_peak_speed
// Running 3-D polyline length and peak speed over a stream of points.
// ----------------------------------------------------------------------------
// One request is one point; each gives one result with the saturating path
// length so far and the peak positive speed. A point that follows another
// of the same trajectory runs the difference, squaring, accumulation and
// square root steps, the square root resolving one bit per cycle; the first
// point after reset or restart skips them. The next request is taken as
// soon as the previous result sits in the output register.
module path_length_and_peak_speed import plp_pkg::*; #(
	parameter int COORD_WIDTH = CoordWidthDef,
	parameter int SUM_WIDTH   = SumWidthDef
) (
	input  logic      clk,
	input  logic      arst_n,
	plp_in_if.sink    point,
	plp_out_if.source result
);

	plp_ctl_t    ctl;
	plp_status_t stat;

	plp_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	plp_datapath #(
		.COORD_WIDTH (COORD_WIDTH),
		.SUM_WIDTH   (SUM_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.stat   (stat),
		.point  (point),
		.result (result)
	);

endmodule

### hw/rtl/plp_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module plp_sequencer import plp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  plp_status_t stat,
	output plp_ctl_t    ctl
);

	plp_pc_t pc_q;
	plp_pc_t pc_next;
	logic    jump;

	assign ctl = plp_ucode(pc_q);

	always_comb begin
		unique case (ctl.cond)
			COND_NEVER:    jump = 1'b0;
			COND_NO_ITEM:  jump = !stat.accept;
			COND_NO_LAST:  jump = !stat.have_last;
			COND_CNT_NZ:   jump = stat.cnt_nz;
			COND_OUT_BUSY: jump = stat.out_busy;
			default:       jump = 1'b0;
		endcase
	end

	always_comb begin
		priority if (jump) begin
			pc_next = ctl.target;
		end else if (ctl.last) begin
			pc_next = STEP_WAIT;
		end else begin
			pc_next = pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_WAIT;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

### hw/rtl/plp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_datapath
// Difference, squaring, accumulation, bit-per-step square root, saturating
// length sum, peak tracking and the output register.
// ----------------------------------------------------------------------------
module plp_datapath import plp_pkg::*; #(
	parameter int COORD_WIDTH = CoordWidthDef,
	parameter int SUM_WIDTH   = SumWidthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  plp_ctl_t    ctl,
	output plp_status_t stat,
	plp_in_if.sink      point,
	plp_out_if.source   result
);

	localparam int RootWidth = COORD_WIDTH + 1;
	localparam int RadWidth  = 2 * RootWidth;
	localparam int RemWidth  = RootWidth + 2;
	localparam int CntWidth  = $clog2(RootWidth);
	localparam int AddWidth  = ((RootWidth > SUM_WIDTH) ? RootWidth : SUM_WIDTH) + 1;

	logic [COORD_WIDTH-1:0]   x_q, y_q, z_q, spd_q;
	logic [COORD_WIDTH-1:0]   last_x_q, last_y_q, last_z_q;
	logic                     have_last_q;
	logic [COORD_WIDTH-1:0]   diff_q;
	logic [2*COORD_WIDTH-1:0] prod_q;
	logic [RadWidth-1:0]      acc_q;
	logic [RadWidth-1:0]      rad_q;
	logic [RemWidth-1:0]      rem_q;
	logic [RootWidth-1:0]     root_q;
	logic [CntWidth-1:0]      cnt_q;
	logic [SUM_WIDTH-1:0]     sum_q;
	logic [COORD_WIDTH-2:0]   peak_q;
	logic                     out_valid_q;
	logic [SUM_WIDTH-1:0]     out_len_q;
	logic [COORD_WIDTH-2:0]   out_peak_q;

	logic                     accept;
	logic                     out_busy;
	logic                     fin_go;
	logic [COORD_WIDTH-1:0]   cur_c, prev_c;
	logic [COORD_WIDTH:0]     sub;
	logic [COORD_WIDTH:0]     mag;
	logic [RemWidth+1:0]      rem_sh;
	logic [RemWidth+1:0]      trial;
	logic                     take_bit;
	logic [RemWidth+1:0]      rem_dif;
	logic [AddWidth-1:0]      len_sum;
	logic                     peak_up;

	assign accept   = ctl.take & point.valid;
	assign out_busy = out_valid_q & ~result.ready;
	assign fin_go   = ctl.fin & ~out_busy;

	assign point.ready = ctl.take;

	assign stat.accept    = accept;
	assign stat.have_last = have_last_q;
	assign stat.cnt_nz    = (cnt_q != '0);
	assign stat.out_busy  = out_busy;

	always_comb begin
		unique case (ctl.axis)
			AXIS_X: begin
				cur_c = x_q;
				prev_c = last_x_q;
			end
			AXIS_Y: begin
				cur_c = y_q;
				prev_c = last_y_q;
			end
			AXIS_Z: begin
				cur_c = z_q;
				prev_c = last_z_q;
			end
			default: begin
				cur_c = x_q;
				prev_c = last_x_q;
			end
		endcase
	end

	assign sub = {cur_c[COORD_WIDTH-1], cur_c} - {prev_c[COORD_WIDTH-1], prev_c};
	assign mag = sub[COORD_WIDTH] ? (~sub + 1'b1) : sub;

	// one root bit per step: bring down two radicand bits, try root*4+1
	assign rem_sh   = {rem_q, rad_q[RadWidth-1 -: 2]};
	assign trial    = {2'b00, root_q, 2'b01};
	assign take_bit = (rem_sh >= trial);
	assign rem_dif  = rem_sh - trial;

	assign len_sum = AddWidth'(sum_q) + AddWidth'(root_q);
	assign peak_up = !spd_q[COORD_WIDTH-1] && (spd_q[COORD_WIDTH-2:0] > peak_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= point.x_coord;
			y_q <= point.y_coord;
			z_q <= point.z_coord;
			spd_q <= point.speed_value;
		end
		if (ctl.ld_diff) begin
			diff_q <= mag[COORD_WIDTH-1:0];
		end
		if (ctl.mul) begin
			prod_q <= diff_q * diff_q;
		end
		if (ctl.acc_clr) begin
			acc_q <= RadWidth'(prod_q);
		end else if (ctl.acc_add) begin
			acc_q <= acc_q + RadWidth'(prod_q);
		end
		if (ctl.sq_init) begin
			rad_q <= acc_q;
			rem_q <= '0;
			root_q <= '0;
			cnt_q <= CntWidth'(RootWidth - 1);
		end else if (ctl.sq_step) begin
			rad_q <= {rad_q[RadWidth-3:0], 2'b00};
			rem_q <= take_bit ? rem_dif[RemWidth-1:0] : rem_sh[RemWidth-1:0];
			root_q <= {root_q[RootWidth-2:0], take_bit};
			cnt_q <= cnt_q - 1'b1;
		end
		if (fin_go) begin
			out_len_q <= sum_q;
			out_peak_q <= peak_up ? spd_q[COORD_WIDTH-2:0] : peak_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= '0;
			last_y_q <= '0;
			last_z_q <= '0;
			have_last_q <= 1'b0;
			sum_q <= '0;
			peak_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && point.restart) begin
				have_last_q <= 1'b0;
				sum_q <= '0;
				peak_q <= '0;
			end
			if (ctl.add_len) begin
				sum_q <= (len_sum[AddWidth-1:SUM_WIDTH] != '0) ? '1
					: len_sum[SUM_WIDTH-1:0];
			end
			if (fin_go) begin
				last_x_q <= x_q;
				last_y_q <= y_q;
				last_z_q <= z_q;
				have_last_q <= 1'b1;
				if (peak_up) begin
					peak_q <= spd_q[COORD_WIDTH-2:0];
				end
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.total_length = out_len_q;
	assign result.peak_speed   = out_peak_q;

endmodule

### hw/rtl/plp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_checker
// Port-level checks: request/result balance and stalled result hold.
// ----------------------------------------------------------------------------
module plp_checker import plp_pkg::*; #(
	parameter int COORD_WIDTH = CoordWidthDef,
	parameter int SUM_WIDTH   = SumWidthDef
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SUM_WIDTH-1:0]   total_length,
	input logic [COORD_WIDTH-2:0] peak_speed
);

	logic [1:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid & in_ready;
	assign out_acc = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	// results only for requests not yet answered
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pending_q != 2'd0))
		else $error("result without pending request");

	// at most one point in work and one result waiting
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q != 2'd3) && !(pending_q == 2'd2 && in_ready))
		else $error("too many requests in flight");

	// a finished result leaves no request unanswered behind it when idle
	a_no_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q == 2'd1 && in_ready && !in_valid) |-> out_valid)
		else $error("request lost");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(total_length) && $stable(peak_speed)))
		else $error("stalled result changed");

endmodule

bind path_length_and_peak_speed plp_checker #(
	.COORD_WIDTH (COORD_WIDTH),
	.SUM_WIDTH   (SUM_WIDTH)
) u_plp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (point.valid),
	.in_ready     (point.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.total_length (result.total_length),
	.peak_speed   (result.peak_speed)
);

### tb/sv/plp_track_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_track_checker
// Watches the point and result channels of path_length_and_peak_speed,
// tracks the running path length and peak speed of every accepted point and
// compares each result with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module plp_track_checker import plp_pkg::*; #(
	parameter int COORD_WIDTH = CoordWidthDef,
	parameter int SUM_WIDTH   = SumWidthDef
) (
	input  logic clk,
	input  logic arst_n,
	plp_in_if    point,
	plp_out_if   result,
	output int   errors,
	output int   outstanding,
	output int   compared
);

	localparam int SqWidth   = 2 * COORD_WIDTH + 2;
	localparam int RootWidth = COORD_WIDTH + 1;
	localparam int GrowWidth = ((RootWidth > SUM_WIDTH) ? RootWidth : SUM_WIDTH) + 1;

	typedef logic [SqWidth-1:0]     square_t;
	typedef logic [RootWidth-1:0]   root_t;
	typedef logic [GrowWidth-1:0]   grown_t;
	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		logic [SUM_WIDTH-1:0]   total_length;
		logic [COORD_WIDTH-2:0] peak_speed;
	} track_result_t;

	coord_t                 prev_x;
	coord_t                 prev_y;
	coord_t                 prev_z;
	logic                   prev_valid;
	logic [SUM_WIDTH-1:0]   run_length;
	logic [COORD_WIDTH-2:0] top_speed;
	track_result_t          expected_q[$];

	function automatic square_t axis_square(input coord_t a, input coord_t b);
		logic signed [COORD_WIDTH:0] d;
		d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
		if (d < 0) begin
			d = -d;
		end
		return square_t'(d) * square_t'(d);
	endfunction

	function automatic track_result_t advance_track(input coord_t x, input coord_t y,
			input coord_t z, input coord_t spd, input logic restart);
		square_t dist_sq;
		root_t   root;
		root_t   trial;
		grown_t  grown;
		if (restart) begin
			prev_valid = 1'b0;
			run_length = '0;
			top_speed  = '0;
		end
		if (prev_valid) begin
			dist_sq = axis_square(x, prev_x) + axis_square(y, prev_y)
				+ axis_square(z, prev_z);
			root = '0;
			// floor square root, one bit at a time from the top
			for (int b = RootWidth - 1; b >= 0; b--) begin
				trial = root | (root_t'(1) << b);
				if (square_t'(trial) * square_t'(trial) <= dist_sq) begin
					root = trial;
				end
			end
			grown = grown_t'(run_length) + grown_t'(root);
			run_length = (grown[GrowWidth-1:SUM_WIDTH] != '0) ? '1
				: grown[SUM_WIDTH-1:0];
		end
		if (spd > 0 && spd[COORD_WIDTH-2:0] > top_speed) begin
			top_speed = spd[COORD_WIDTH-2:0];
		end
		prev_x     = x;
		prev_y     = y;
		prev_z     = z;
		prev_valid = 1'b1;
		return '{total_length: run_length, peak_speed: top_speed};
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		track_result_t want;
		track_result_t fresh;
		if (!arst_n) begin
			prev_x     = '0;
			prev_y     = '0;
			prev_z     = '0;
			prev_valid = 1'b0;
			run_length = '0;
			top_speed  = '0;
			expected_q.delete();
		end else begin
			if (result.valid && result.ready) begin
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: expected none, actual total %0d peak %0d",
						$time, result.total_length, result.peak_speed);
				end else begin
					want = expected_q.pop_front();
					compared++;
					if (result.total_length !== want.total_length) begin
						errors++;
						$display("%0t: total_length expected %0d actual %0d",
							$time, want.total_length, result.total_length);
					end
					if (result.peak_speed !== want.peak_speed) begin
						errors++;
						$display("%0t: peak_speed expected %0d actual %0d",
							$time, want.peak_speed, result.peak_speed);
					end
				end
			end
			if (point.valid && point.ready) begin
				fresh = advance_track(point.x_coord, point.y_coord,
					point.z_coord, point.speed_value, point.restart);
				expected_q = {expected_q, fresh};
			end
		end
		outstanding = expected_q.size();
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives trajectory points into path_length_and_peak_speed with random gaps
// and result back-pressure: a directed opening, then random trajectories of
// small steps, wide jumps and corner points, and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import plp_pkg::*;

	localparam int CW          = CoordWidthDef;
	localparam int TotalPoints = 850;
	localparam int IdleLimit   = 2000;
	localparam int TailCycles  = 40;

	typedef logic signed [CW-1:0] coord_t;

	localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

	logic clk = 1'b0;
	logic arst_n;
	bit   calm;
	int   stall_left;
	int   idle_cycles;
	int   sent;
	int   restarts;
	int   errors;
	int   outstanding;
	int   compared;

	always #5 clk = ~clk;

	plp_in_if  point_ch ();
	plp_out_if result_ch ();

	path_length_and_peak_speed dut (
		.clk    (clk),
		.arst_n (arst_n),
		.point  (point_ch),
		.result (result_ch)
	);

	plp_track_checker track_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.point       (point_ch),
		.result      (result_ch),
		.errors      (errors),
		.outstanding (outstanding),
		.compared    (compared)
	);

	// result back-pressure: mostly short stalls, a few long ones
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (calm) begin
			result_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_ch.ready <= 1'b0;
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: result_ch.ready <= 1'b1;
				9: begin
					result_ch.ready <= 1'b0;
					stall_left <= $urandom_range(10, 60);
				end
				default: begin
					result_ch.ready <= 1'b0;
					stall_left <= $urandom_range(0, 2);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IdleLimit) begin
				$display("%0t: no request or result moved for %0d cycles", $time, IdleLimit);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(5, 40);
	endfunction

	function automatic coord_t pick_corner();
		case ($urandom_range(0, 3))
			0: return CMAX;
			1: return CMIN;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic coord_t nudge(input coord_t c);
		return coord_t'(int'(c) + int'($urandom_range(0, 4095)) - 2048);
	endfunction

	function automatic coord_t pick_speed();
		case ($urandom_range(0, 7))
			0: return coord_t'($urandom_range(0, 1000));
			1: return CMAX;
			2: return CMIN;
			3: return pick_corner();
			default: return coord_t'($urandom);
		endcase
	endfunction

	task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
			input coord_t spd, input logic restart);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			point_ch.valid <= 1'b0;
		end
		@(negedge clk);
		point_ch.valid       <= 1'b1;
		point_ch.x_coord     <= x;
		point_ch.y_coord     <= y;
		point_ch.z_coord     <= z;
		point_ch.speed_value <= spd;
		point_ch.restart     <= restart;
		do @(posedge clk); while (!point_ch.ready);
		sent++;
		if (restart) begin
			restarts++;
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		point_ch.valid <= 1'b0;
		while (outstanding != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin : stimulus
		int     traj_len;
		int     style;
		bit     held;
		coord_t px;
		coord_t py;
		coord_t pz;
		point_ch.valid       = 1'b0;
		point_ch.x_coord     = '0;
		point_ch.y_coord     = '0;
		point_ch.z_coord     = '0;
		point_ch.speed_value = '0;
		point_ch.restart     = 1'b0;
		arst_n               = 1'b0;
		held                 = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// first point after reset, negative speed never raises the peak
		send_point('0, '0, '0, '1, 1'b0);
		send_point(CMAX, CMAX, CMAX, CMAX, 1'b0);
		send_point(CMIN, CMIN, CMIN, CMIN, 1'b0);
		send_point(CMAX, CMIN, CMAX, coord_t'(1), 1'b0);
		// repeated point adds nothing
		send_point(CMAX, CMIN, CMAX, '0, 1'b0);
		// exact and inexact roots from a fresh trajectory
		send_point('0, '0, '0, coord_t'(5), 1'b1);
		send_point(coord_t'(768), coord_t'(1024), '0, coord_t'(4), 1'b0);
		send_point(coord_t'(769), coord_t'(1024), '0, coord_t'(6), 1'b0);
		send_point(coord_t'(770), coord_t'(1025), coord_t'(1), '1, 1'b0);
		// restart on consecutive points
		send_point(CMIN, CMAX, CMIN, CMIN, 1'b1);
		send_point(CMIN, CMAX, CMIN, CMAX, 1'b1);
		send_point('1, '1, '1, '1, 1'b1);
		send_point('0, '0, '0, coord_t'(100), 1'b0);
		send_point(CMAX, CMAX, CMAX, coord_t'(99), 1'b0);
		send_point(CMIN, CMIN, CMIN, '0, 1'b0);
		send_point(CMAX, CMAX, CMAX, CMIN, 1'b0);
		send_point(CMIN, CMAX, '0, CMAX, 1'b0);
		drain_results();

		while (sent < TotalPoints) begin
			calm = (sent > 300 && sent < 380);
			if (sent >= 550 && !held) begin
				drain_results();
				held = 1'b1;
			end
			style = $urandom_range(0, 9);
			traj_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 12);
			px = coord_t'($urandom);
			py = coord_t'($urandom);
			pz = coord_t'($urandom);
			for (int k = 0; k < traj_len; k++) begin
				if (k > 0) begin
					if (style < 5) begin
						px = nudge(px);
						py = nudge(py);
						pz = nudge(pz);
					end else if (style < 8) begin
						px = coord_t'($urandom);
						py = coord_t'($urandom);
						pz = coord_t'($urandom);
					end else begin
						px = pick_corner();
						py = pick_corner();
						pz = pick_corner();
					end
				end
				send_point(px, py, pz, pick_speed(),
					(k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0));
			end
		end

		drain_results();
		repeat (TailCycles) @(negedge clk);
		$display("sent %0d points, %0d of them restarts, %0d results compared",
			sent, restarts, compared);
		$display("covered corner jumps, exact roots, repeated points and stalls on both sides");
		if (errors == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
